@@ rtl/hpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hpsc_pkg
// Shared types, codes and constants for the hub port status controller.
// ----------------------------------------------------------------------------
package hpsc_pkg;

  localparam int PORT_COUNT_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int PORT_FIELD_W    = 4;   // holds a port number up to fifteen

  // handshake codes
  localparam logic [1:0] HS_ACK    = 2'd0;
  localparam logic [1:0] HS_STALL  = 2'd1;
  localparam logic [1:0] HS_NAK    = 2'd2;
  localparam logic [1:0] HS_BABBLE = 2'd3;

  // port status bits
  localparam logic [9:0] ST_CONN     = 10'h001;
  localparam logic [9:0] ST_ENABLE   = 10'h002;
  localparam logic [9:0] ST_SUSPEND  = 10'h004;
  localparam logic [9:0] ST_POWER    = 10'h100;
  localparam logic [9:0] ST_LOWSPEED = 10'h200;

  // port change bits
  localparam logic [4:0] CH_CONN    = 5'h01;
  localparam logic [4:0] CH_ENABLE  = 5'h02;
  localparam logic [4:0] CH_SUSPEND = 5'h04;
  localparam logic [4:0] CH_OVERCUR = 5'h08;
  localparam logic [4:0] CH_RESET   = 5'h10;

  // control requests: bmRequestType, bRequest
  localparam logic [15:0] REQ_CLR_EP_FEATURE = 16'h0201;
  localparam logic [15:0] REQ_GET_HUB_STATUS = 16'hA000;
  localparam logic [15:0] REQ_GET_PORT_STAT  = 16'hA300;
  localparam logic [15:0] REQ_SET_HUB_FEAT   = 16'h2003;
  localparam logic [15:0] REQ_CLR_HUB_FEAT   = 16'h2001;
  localparam logic [15:0] REQ_SET_PORT_FEAT  = 16'h2303;
  localparam logic [15:0] REQ_CLR_PORT_FEAT  = 16'h2301;
  localparam logic [15:0] REQ_GET_HUB_DESC   = 16'hA006;

  localparam logic [15:0] INTR_EP_ADDR = 16'h0081;

  // feature selectors
  localparam logic [15:0] FEAT_EP_HALT     = 16'd0;
  localparam logic [15:0] FEAT_HUB_LOCAL   = 16'd0;
  localparam logic [15:0] FEAT_HUB_OVERCUR = 16'd1;
  localparam logic [15:0] FEAT_ENABLE      = 16'd1;
  localparam logic [15:0] FEAT_SUSPEND     = 16'd2;
  localparam logic [15:0] FEAT_RESET       = 16'd4;
  localparam logic [15:0] FEAT_POWER       = 16'd8;
  localparam logic [15:0] FEAT_C_CONN      = 16'd16;
  localparam logic [15:0] FEAT_C_ENABLE    = 16'd17;
  localparam logic [15:0] FEAT_C_SUSPEND   = 16'd18;
  localparam logic [15:0] FEAT_C_OVERCUR   = 16'd19;
  localparam logic [15:0] FEAT_C_RESET     = 16'd20;

  localparam logic [3:0] INTR_EP = 4'd1;

  typedef enum logic [2:0] {
    ACT_CONTROL   = 3'd0,
    ACT_IN        = 3'd1,
    ACT_OUT       = 3'd2,
    ACT_ATTACH    = 3'd3,
    ACT_DETACH    = 3'd4,
    ACT_WAKEUP    = 3'd5,
    ACT_HUB_RESET = 3'd6,
    ACT_NONE      = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    K_ACK,
    K_STALL,
    K_HUB_STATUS,
    K_PORT_STATUS,
    K_SET_SUSPEND,
    K_SET_RESET,
    K_PORT_CLEAR,
    K_DESC,
    K_INTR,
    K_ATTACH,
    K_DETACH,
    K_WAKE,
    K_HUB_RESET
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [PORT_FIELD_W-1:0] port;
    logic                    low_speed;
    logic [9:0]              clr_status;
    logic [4:0]              clr_change;
    logic [6:0]              buffer_size;
  } cmd_t;

  // hub descriptor, ten bytes
  function automatic logic [7:0] desc_byte(input logic [3:0] idx, input logic [7:0] nports);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h0A;
      4'd1:    b = 8'h29;
      4'd2:    b = nports;
      4'd3:    b = 8'h0A;
      4'd5:    b = 8'h01;
      4'd9:    b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/hpsc_ifs.sv @@
// ----------------------------------------------------------------------------
// hpsc channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface hpsc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] request;
  logic [15:0] feature_value;
  logic [15:0] port_index;
  logic [2:0]  event_port;
  logic        low_speed;
  logic [3:0]  endpoint;
  logic [6:0]  buffer_size;

  modport source (output valid, action, request, feature_value, port_index, event_port,
                  low_speed, endpoint, buffer_size, input ready);
  modport sink   (input valid, action, request, feature_value, port_index, event_port,
                  low_speed, endpoint, buffer_size, output ready);
endinterface

interface hpsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] handshake;
  logic [7:0] data_byte;
  logic       has_data;
  logic       last;
  logic       wake_interrupt;

  modport source (output valid, handshake, data_byte, has_data, last, wake_interrupt,
                  input ready);
  modport sink   (input valid, handshake, data_byte, has_data, last, wake_interrupt,
                  output ready);
endinterface

@@ rtl/hpsc_front.sv @@
// ----------------------------------------------------------------------------
// hpsc_front
// Decodes an incoming word into an executor command; no state involved.
// ----------------------------------------------------------------------------
module hpsc_front #(
  parameter int PORT_COUNT = hpsc_pkg::PORT_COUNT_DEF
) (
  hpsc_in_if.sink          in_word,
  input  logic             q_full,
  output logic             push,
  output hpsc_pkg::cmd_t   push_cmd
);

  logic [15:0] port_num;
  logic        port_ok;
  logic        ev_ok;
  logic [15:0] val;

  assign in_word.ready = !q_full;
  assign push = in_word.valid && !q_full &&
                (in_word.action != hpsc_pkg::ACT_NONE);

  assign val      = in_word.feature_value;
  assign port_num = in_word.port_index - 16'd1;
  assign port_ok  = 32'(port_num) < PORT_COUNT;
  assign ev_ok    = 32'(in_word.event_port) < PORT_COUNT;

  always_comb begin
    push_cmd             = '0;
    push_cmd.kind        = hpsc_pkg::K_STALL;
    push_cmd.low_speed   = in_word.low_speed;
    push_cmd.buffer_size = in_word.buffer_size;
    case (in_word.action)
      hpsc_pkg::ACT_CONTROL: begin
        push_cmd.port = port_num[hpsc_pkg::PORT_FIELD_W-1:0];
        case (in_word.request)
          hpsc_pkg::REQ_CLR_EP_FEATURE: begin
            if (!(val == hpsc_pkg::FEAT_EP_HALT &&
                  in_word.port_index != hpsc_pkg::INTR_EP_ADDR)) begin
              push_cmd.kind = hpsc_pkg::K_ACK;
            end
          end
          hpsc_pkg::REQ_GET_HUB_STATUS: push_cmd.kind = hpsc_pkg::K_HUB_STATUS;
          hpsc_pkg::REQ_GET_PORT_STAT: begin
            if (port_ok) push_cmd.kind = hpsc_pkg::K_PORT_STATUS;
          end
          hpsc_pkg::REQ_SET_HUB_FEAT, hpsc_pkg::REQ_CLR_HUB_FEAT: begin
            if (val inside {hpsc_pkg::FEAT_HUB_LOCAL, hpsc_pkg::FEAT_HUB_OVERCUR}) begin
              push_cmd.kind = hpsc_pkg::K_ACK;
            end
          end
          hpsc_pkg::REQ_SET_PORT_FEAT: begin
            if (port_ok) begin
              case (val)
                hpsc_pkg::FEAT_SUSPEND: push_cmd.kind = hpsc_pkg::K_SET_SUSPEND;
                hpsc_pkg::FEAT_RESET:   push_cmd.kind = hpsc_pkg::K_SET_RESET;
                hpsc_pkg::FEAT_POWER:   push_cmd.kind = hpsc_pkg::K_ACK;
                default:                push_cmd.kind = hpsc_pkg::K_STALL;
              endcase
            end
          end
          hpsc_pkg::REQ_CLR_PORT_FEAT: begin
            if (port_ok) begin
              push_cmd.kind = hpsc_pkg::K_PORT_CLEAR;
              case (val)
                hpsc_pkg::FEAT_ENABLE:    push_cmd.clr_status = hpsc_pkg::ST_ENABLE;
                hpsc_pkg::FEAT_SUSPEND:   push_cmd.clr_status = hpsc_pkg::ST_SUSPEND;
                hpsc_pkg::FEAT_C_ENABLE:  push_cmd.clr_change = hpsc_pkg::CH_ENABLE;
                hpsc_pkg::FEAT_C_SUSPEND: push_cmd.clr_change = hpsc_pkg::CH_SUSPEND;
                hpsc_pkg::FEAT_C_CONN:    push_cmd.clr_change = hpsc_pkg::CH_CONN;
                hpsc_pkg::FEAT_C_OVERCUR: push_cmd.clr_change = hpsc_pkg::CH_OVERCUR;
                hpsc_pkg::FEAT_C_RESET:   push_cmd.clr_change = hpsc_pkg::CH_RESET;
                default:                  push_cmd.kind       = hpsc_pkg::K_STALL;
              endcase
            end
          end
          hpsc_pkg::REQ_GET_HUB_DESC: push_cmd.kind = hpsc_pkg::K_DESC;
          default:                    push_cmd.kind = hpsc_pkg::K_STALL;
        endcase
      end
      hpsc_pkg::ACT_IN: begin
        if (in_word.endpoint == hpsc_pkg::INTR_EP) push_cmd.kind = hpsc_pkg::K_INTR;
      end
      hpsc_pkg::ACT_ATTACH, hpsc_pkg::ACT_DETACH, hpsc_pkg::ACT_WAKEUP: begin
        // out-of-range event port: plain ack, no state change
        push_cmd.port = hpsc_pkg::PORT_FIELD_W'(in_word.event_port);
        if (!ev_ok) begin
          push_cmd.kind = hpsc_pkg::K_ACK;
        end else if (in_word.action == hpsc_pkg::ACT_ATTACH) begin
          push_cmd.kind = hpsc_pkg::K_ATTACH;
        end else if (in_word.action == hpsc_pkg::ACT_DETACH) begin
          push_cmd.kind = hpsc_pkg::K_DETACH;
        end else begin
          push_cmd.kind = hpsc_pkg::K_WAKE;
        end
      end
      hpsc_pkg::ACT_HUB_RESET: push_cmd.kind = hpsc_pkg::K_HUB_RESET;
      default:                 push_cmd.kind = hpsc_pkg::K_STALL;
    endcase
  end

endmodule

@@ rtl/hpsc_queue.sv @@
// ----------------------------------------------------------------------------
// hpsc_queue
// Small command queue between decoder and executor.
// ----------------------------------------------------------------------------
module hpsc_queue #(
  parameter int DEPTH = hpsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hpsc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output hpsc_pkg::cmd_t q_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hpsc_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

@@ rtl/hpsc_exec.sv @@
// ----------------------------------------------------------------------------
// hpsc_exec
// Holds per-port state, applies commands, streams result words.
// ----------------------------------------------------------------------------
module hpsc_exec #(
  parameter int PORT_COUNT = hpsc_pkg::PORT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  hpsc_pkg::cmd_t q_cmd,
  output logic           pop,
  hpsc_out_if.source     out_word
);

  localparam int PW     = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int NBYTES = (PORT_COUNT + 8) / 8;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  state_t         st_r, st_nxt;
  hpsc_pkg::kind_t kind_r, kind_nxt;
  logic [PW-1:0]  port_r, port_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic [3:0]     last_idx_r, last_idx_nxt;
  logic [1:0]     hs_r, hs_nxt;
  logic           wake_r, wake_nxt;

  logic [9:0] status_r  [PORT_COUNT];
  logic [9:0] status_nxt[PORT_COUNT];
  logic [4:0] change_r  [PORT_COUNT];
  logic [4:0] change_nxt[PORT_COUNT];
  logic       present_r [PORT_COUNT];
  logic       present_nxt[PORT_COUNT];
  logic       lowspd_r  [PORT_COUNT];
  logic       lowspd_nxt[PORT_COUNT];

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_hs_r, out_hs_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_has_r, out_has_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_wake_r, out_wake_nxt;

  logic [PW-1:0]     rd_port;
  logic [9:0]        pst;
  logic [4:0]        pch;
  logic              pdev;
  logic [PORT_COUNT:0] bitmap;
  logic [15:0]       bitmap16;
  logic              slot_free;
  logic              has_data;
  logic [7:0]        data_b;

  assign out_word.valid          = out_valid_r;
  assign out_word.handshake      = out_hs_r;
  assign out_word.data_byte      = out_byte_r;
  assign out_word.has_data       = out_has_r;
  assign out_word.last           = out_last_r;
  assign out_word.wake_interrupt = out_wake_r;

  assign slot_free = !out_valid_r || out_word.ready;

  // single port read: the queue head while dispatching, the latched port after
  assign rd_port = (st_r == S_IDLE) ? q_cmd.port[PW-1:0] : port_r;
  assign pst     = status_r[rd_port];
  assign pch     = change_r[rd_port];
  assign pdev    = present_r[rd_port];

  // interrupt endpoint bitmap, bit n for port n
  always_comb begin
    bitmap = '0;
    for (int i = 0; i < PORT_COUNT; i++) begin
      bitmap[i+1] = (change_r[i] != '0);
    end
  end
  assign bitmap16 = 16'(bitmap);

  // result byte for the current index
  always_comb begin
    has_data = 1'b0;
    data_b   = 8'h00;
    if (hs_r == hpsc_pkg::HS_ACK) begin
      case (kind_r)
        hpsc_pkg::K_HUB_STATUS: has_data = 1'b1;
        hpsc_pkg::K_PORT_STATUS: begin
          has_data = 1'b1;
          case (idx_r)
            4'd0:    data_b = pst[7:0];
            4'd1:    data_b = {6'b0, pst[9:8]};
            4'd2:    data_b = {3'b0, pch};
            default: data_b = 8'h00;
          endcase
        end
        hpsc_pkg::K_DESC: begin
          has_data = 1'b1;
          data_b   = hpsc_pkg::desc_byte(idx_r, 8'(PORT_COUNT));
        end
        hpsc_pkg::K_INTR: begin
          has_data = 1'b1;
          data_b   = idx_r[0] ? bitmap16[15:8] : bitmap16[7:0];
        end
        default: has_data = 1'b0;
      endcase
    end
  end

  always_comb begin
    st_nxt       = st_r;
    kind_nxt     = kind_r;
    port_nxt     = port_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    hs_nxt       = hs_r;
    wake_nxt     = wake_r;
    status_nxt   = status_r;
    change_nxt   = change_r;
    present_nxt  = present_r;
    lowspd_nxt   = lowspd_r;
    pop          = 1'b0;

    out_valid_nxt = out_valid_r && !out_word.ready;
    out_hs_nxt    = out_hs_r;
    out_byte_nxt  = out_byte_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    out_wake_nxt  = out_wake_r;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          // dispatch: update state, fix handshake, count and wake
          pop          = 1'b1;
          st_nxt       = S_BUSY;
          kind_nxt     = q_cmd.kind;
          port_nxt     = rd_port;
          idx_nxt      = '0;
          last_idx_nxt = '0;
          hs_nxt       = hpsc_pkg::HS_ACK;
          wake_nxt     = 1'b0;
          case (q_cmd.kind)
            hpsc_pkg::K_STALL:       hs_nxt = hpsc_pkg::HS_STALL;
            hpsc_pkg::K_HUB_STATUS:  last_idx_nxt = 4'd3;
            hpsc_pkg::K_PORT_STATUS: last_idx_nxt = 4'd3;
            hpsc_pkg::K_DESC:        last_idx_nxt = 4'd9;
            hpsc_pkg::K_SET_SUSPEND: status_nxt[rd_port] = pst | hpsc_pkg::ST_SUSPEND;
            hpsc_pkg::K_SET_RESET: begin
              // port reset without a device is acked and does nothing
              if (pdev) begin
                change_nxt[rd_port] = pch | hpsc_pkg::CH_RESET;
                status_nxt[rd_port] = pst | hpsc_pkg::ST_ENABLE;
                wake_nxt            = 1'b1;
              end
            end
            hpsc_pkg::K_PORT_CLEAR: begin
              status_nxt[rd_port] = pst & ~q_cmd.clr_status;
              change_nxt[rd_port] = pch & ~q_cmd.clr_change;
            end
            hpsc_pkg::K_INTR: begin
              if (bitmap == '0) begin
                hs_nxt = hpsc_pkg::HS_NAK;
              end else if (q_cmd.buffer_size == 7'd1) begin
                last_idx_nxt = '0;
              end else if (7'(NBYTES) > q_cmd.buffer_size) begin
                hs_nxt = hpsc_pkg::HS_BABBLE;
              end else begin
                last_idx_nxt = 4'(NBYTES - 1);
              end
            end
            hpsc_pkg::K_ATTACH: begin
              present_nxt[rd_port] = 1'b1;
              lowspd_nxt[rd_port]  = q_cmd.low_speed;
              status_nxt[rd_port]  = q_cmd.low_speed ?
                                     (pst | hpsc_pkg::ST_CONN | hpsc_pkg::ST_LOWSPEED) :
                                     ((pst | hpsc_pkg::ST_CONN) & ~hpsc_pkg::ST_LOWSPEED);
              change_nxt[rd_port]  = pch | hpsc_pkg::CH_CONN;
              wake_nxt             = 1'b1;
            end
            hpsc_pkg::K_DETACH: begin
              // applied even when nothing is attached
              present_nxt[rd_port] = 1'b0;
              lowspd_nxt[rd_port]  = 1'b0;
              status_nxt[rd_port]  = pst & ~(hpsc_pkg::ST_CONN | hpsc_pkg::ST_ENABLE);
              change_nxt[rd_port]  = pch | hpsc_pkg::CH_CONN |
                                     (((pst & hpsc_pkg::ST_ENABLE) != '0) ?
                                      hpsc_pkg::CH_ENABLE : 5'h00);
              wake_nxt             = 1'b1;
            end
            hpsc_pkg::K_WAKE: begin
              if ((pst & hpsc_pkg::ST_SUSPEND) != '0) begin
                change_nxt[rd_port] = pch | hpsc_pkg::CH_SUSPEND;
                wake_nxt            = 1'b1;
              end
            end
            hpsc_pkg::K_HUB_RESET: begin
              for (int i = 0; i < PORT_COUNT; i++) begin
                status_nxt[i] = hpsc_pkg::ST_POWER;
                change_nxt[i] = '0;
                if (present_r[i]) begin
                  status_nxt[i] = hpsc_pkg::ST_POWER | hpsc_pkg::ST_CONN |
                                  (lowspd_r[i] ? hpsc_pkg::ST_LOWSPEED : 10'h000);
                  change_nxt[i] = hpsc_pkg::CH_CONN;
                end
              end
            end
            default: hs_nxt = hpsc_pkg::HS_ACK;
          endcase
        end
      end
      S_BUSY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_hs_nxt    = hs_r;
          out_byte_nxt  = data_b;
          out_has_nxt   = has_data;
          out_last_nxt  = (idx_r == last_idx_r);
          out_wake_nxt  = wake_r;
          idx_nxt       = idx_r + 4'd1;
          if (idx_r == last_idx_r) st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        status_r[i]  <= hpsc_pkg::ST_POWER;
        change_r[i]  <= '0;
        present_r[i] <= 1'b0;
        lowspd_r[i]  <= 1'b0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      change_r    <= change_nxt;
      present_r   <= present_nxt;
      lowspd_r    <= lowspd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    port_r     <= port_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    hs_r       <= hs_nxt;
    wake_r     <= wake_nxt;
    out_hs_r   <= out_hs_nxt;
    out_byte_r <= out_byte_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_wake_r <= out_wake_nxt;
  end

endmodule

@@ rtl/usb_hub_port_status_controller.sv @@
// Path: when the command queue and executor are empty, the first result word of an
//   item passes through the queue, the executor's dispatch step and its output register.
// Flow: an item of n result words holds the executor for a dispatch step, then one
//   word per cycle while the output is not stalled; the queue takes further items
//   meanwhile. Sync reset: queue and output empty, all ports power only.
// ----------------------------------------------------------------------------
// usb_hub_port_status_controller
// Hub-class logic of a USB 1.1 hub: port status/change tracking, hub-class
// control requests, interrupt endpoint polls and attach/detach/wake events.
// ----------------------------------------------------------------------------
module usb_hub_port_status_controller #(
  parameter int PORT_COUNT  = hpsc_pkg::PORT_COUNT_DEF,
  parameter int QUEUE_DEPTH = hpsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hpsc_in_if.sink     in_word,
  hpsc_out_if.source  out_word
);

  // decoder -> queue
  logic           push;
  hpsc_pkg::cmd_t push_cmd;
  logic           q_full;

  // queue -> executor
  logic           q_valid;
  logic           pop;
  hpsc_pkg::cmd_t q_cmd;

  // Front end: pure decode of the request word into a command. All checks
  // that need only the word (request code, selector, port range) are done
  // here; anything that reads port state is left to the executor.
  hpsc_front #(
    .PORT_COUNT (PORT_COUNT)
  ) u_front (
    .in_word  (in_word),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouples intake from result streaming.
  hpsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back end: owns the port state; one command at a time, updates applied
  // at dispatch, then result words through a registered output slot.
  hpsc_exec #(
    .PORT_COUNT (PORT_COUNT)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule

@@ rtl/hpsc_checker.sv @@
// ----------------------------------------------------------------------------
// hpsc_checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hpsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] handshake,
  input logic [7:0] data_byte,
  input logic       has_data,
  input logic       last,
  input logic       wake
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last))
    else $error("result word changed while stalled");

  // data only on acked transfers
  a_data_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_data |-> handshake == hpsc_pkg::HS_ACK)
    else $error("data word with non-ack handshake");

  // empty words carry zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_data |-> data_byte == 8'h00)
    else $error("nonzero byte without data");

  // stall, nak and babble are single-word responses
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && handshake != hpsc_pkg::HS_ACK |-> last && !has_data)
    else $error("error handshake not a single word");

  // wake flag is the same on consecutive words of one item
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last ##1 out_valid |-> wake == $past(wake))
    else $error("wake flag changed within an item");

endmodule

bind usb_hub_port_status_controller hpsc_checker u_hpsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .handshake (out_word.handshake),
  .data_byte (out_word.data_byte),
  .has_data  (out_word.has_data),
  .last      (out_word.last),
  .wake      (out_word.wake_interrupt)
);
